// ----- rtl/core/bmp_rgb24_stream_parser_macros.svh -----
// Assertion macros for the BMP stream parser RTL.
// Standalone header; included by modules that carry concurrent checks.
`ifndef BMP_RGB24_STREAM_PARSER_MACROS_SVH
`define BMP_RGB24_STREAM_PARSER_MACROS_SVH

`ifndef SYNTHESIS
// Check with an explicit clock and synchronous reset
`define BMP_ASSERT_CLK(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("bmp parser assertion failed");
// Check on the module's clk and rst
`define BMP_ASSERT(lbl, prop) \
  `BMP_ASSERT_CLK(lbl, clk, rst, prop)
`else
`define BMP_ASSERT_CLK(lbl, ck, rs, prop)
`define BMP_ASSERT(lbl, prop)
`endif

`endif

// ----- rtl/core/bmp24_pkg.sv -----
// Shared types and constants for the 24-bit BMP stream parser.
// No dependencies.
`default_nettype none

package bmp24_pkg;

  // Header layout (14-byte file header, 40-byte info header)
  localparam int unsigned FILE_HDR_BYTES = 14;
  localparam int unsigned INFO_HDR_BYTES = 40;
  localparam logic [5:0]  WIDTH_OFS      = 6'(FILE_HDR_BYTES + 4);
  localparam logic [5:0]  HEIGHT_OFS     = 6'(FILE_HDR_BYTES + 8);
  localparam logic [5:0]  HEADER_LAST    = 6'(FILE_HDR_BYTES + INFO_HDR_BYTES - 1);
  localparam logic [5:0]  IDX_MAGIC0     = 6'd0;
  localparam logic [5:0]  IDX_MAGIC1     = 6'd1;
  localparam logic [7:0]  MAGIC_FIRST    = 8'h42;  // 'B'
  localparam logic [7:0]  MAGIC_SECOND   = 8'h4D;  // 'M'

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_PIXELS  = 3'd2,
    PH_PADDING = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DIMS      = 2'd0,
    KIND_PIXEL     = 2'd1,
    KIND_NOT_BMP   = 2'd2,
    KIND_TOO_LARGE = 2'd3
  } kind_t;

  // One result item from the parser core
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] pixel_column;
    logic [15:0] pixel_row;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        last_pixel;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/bmp24_parse.sv -----
// Parser core: file state and per-byte decode, one byte per step.
// Depends on bmp24_pkg.
`default_nettype none

module bmp24_parse
  import bmp24_pkg::*;
#(
  parameter int unsigned DIM_BITS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step,
  input  wire logic [7:0] data_byte,
  input  wire logic    file_start,
  output result_t      res
);

  phase_t      phase, phase_next;
  logic [5:0]  header_index, header_index_next;
  logic [31:0] width_reg, width_reg_next;
  logic [31:0] height_reg, height_reg_next;
  logic [15:0] column_count, column_count_next;
  logic [15:0] row_count, row_count_next;
  logic [1:0]  triple_index, triple_index_next;
  logic [7:0]  held_blue, held_blue_next;
  logic [7:0]  held_green, held_green_next;
  logic [1:0]  padding_left, padding_left_next;

  // State seen by this byte: a file start clears everything first
  phase_t      cur_phase;
  logic [5:0]  cur_idx;
  logic [31:0] cur_width, cur_height;
  logic [15:0] cur_col, cur_row;
  logic [1:0]  cur_triple, cur_pad;
  logic [7:0]  cur_blue, cur_green;

  assign cur_phase  = file_start ? PH_HEADER : phase;
  assign cur_idx    = file_start ? 6'd0  : header_index;
  assign cur_width  = file_start ? 32'd0 : width_reg;
  assign cur_height = file_start ? 32'd0 : height_reg;
  assign cur_col    = file_start ? 16'd0 : column_count;
  assign cur_row    = file_start ? 16'd0 : row_count;
  assign cur_triple = file_start ? 2'd0  : triple_index;
  assign cur_pad    = file_start ? 2'd0  : padding_left;
  assign cur_blue   = file_start ? 8'd0  : held_blue;
  assign cur_green  = file_start ? 8'd0  : held_green;

  // Shared decode terms
  logic        magic_bad;
  logic        in_width, in_height;
  logic [1:0]  width_sel, height_sel;
  logic [31:0] width_cap, height_cap;
  logic        dims_fit;
  logic        row_end, image_end;

  assign magic_bad = ((cur_idx == IDX_MAGIC0) && (data_byte != MAGIC_FIRST)) ||
                     ((cur_idx == IDX_MAGIC1) && (data_byte != MAGIC_SECOND));
  assign in_width   = (cur_idx >= WIDTH_OFS) && (cur_idx < WIDTH_OFS + 6'd4);
  assign in_height  = (cur_idx >= HEIGHT_OFS) && (cur_idx < HEIGHT_OFS + 6'd4);
  assign width_sel  = 2'(cur_idx - WIDTH_OFS);
  assign height_sel = 2'(cur_idx - HEIGHT_OFS);
  assign width_cap  = in_width ?
                      (cur_width | (32'(data_byte) << {width_sel, 3'b000})) : cur_width;
  assign height_cap = in_height ?
                      (cur_height | (32'(data_byte) << {height_sel, 3'b000})) : cur_height;

  // A dimension fits below 2^DIM_BITS and below the 16-bit counter range
  assign dims_fit = (width_cap[31:16] == 16'd0) && ((width_cap >> DIM_BITS) == 32'd0) &&
                    (height_cap[31:16] == 16'd0) && ((height_cap >> DIM_BITS) == 32'd0);

  // Dimensions already fit in 16 bits while pixels are decoded
  assign row_end   = ({1'b0, cur_col} + 17'd1) >= {1'b0, cur_width[15:0]};
  assign image_end = ({1'b0, cur_row} + 17'd1) >= {1'b0, cur_height[15:0]};

  // Next state
  always_comb begin
    phase_next         = cur_phase;
    header_index_next  = cur_idx;
    width_reg_next     = cur_width;
    height_reg_next    = cur_height;
    column_count_next  = cur_col;
    row_count_next     = cur_row;
    triple_index_next  = cur_triple;
    held_blue_next     = cur_blue;
    held_green_next    = cur_green;
    padding_left_next  = cur_pad;
    case (cur_phase)
      PH_HEADER: begin
        if (magic_bad) begin
          phase_next = PH_DONE;
        end else begin
          width_reg_next  = width_cap;
          height_reg_next = height_cap;
          if (cur_idx >= HEADER_LAST) begin
            if (dims_fit && (width_cap != 32'd0) && (height_cap != 32'd0)) begin
              phase_next = PH_PIXELS;
            end else begin
              phase_next = PH_DONE;
            end
          end else begin
            header_index_next = cur_idx + 6'd1;
          end
        end
      end
      PH_PIXELS: begin
        if (cur_triple == 2'd0) begin
          held_blue_next    = data_byte;
          triple_index_next = 2'd1;
        end else if (cur_triple == 2'd1) begin
          held_green_next   = data_byte;
          triple_index_next = 2'd2;
        end else begin
          triple_index_next = 2'd0;
          if (row_end) begin
            if (image_end) begin
              phase_next = PH_DONE;
            end else begin
              column_count_next = 16'd0;
              row_count_next    = cur_row + 16'd1;
              padding_left_next = cur_width[1:0];
              if (cur_width[1:0] != 2'd0) begin
                phase_next = PH_PADDING;
              end
            end
          end else begin
            column_count_next = cur_col + 16'd1;
          end
        end
      end
      PH_PADDING: begin
        padding_left_next = (cur_pad != 2'd0) ? cur_pad - 2'd1 : cur_pad;
        if (padding_left_next == 2'd0) begin
          phase_next = PH_PIXELS;
        end
      end
      default: begin
      end
    endcase
  end

  // Result item for this byte
  always_comb begin
    res = '0;
    res.kind = KIND_DIMS;
    case (cur_phase)
      PH_HEADER: begin
        if (magic_bad) begin
          res.valid = 1'b1;
          res.kind  = KIND_NOT_BMP;
        end else if (cur_idx >= HEADER_LAST) begin
          res.valid        = 1'b1;
          res.kind         = dims_fit ? KIND_DIMS : KIND_TOO_LARGE;
          res.image_width  = width_cap[15:0];
          res.image_height = height_cap[15:0];
        end
      end
      PH_PIXELS: begin
        if (cur_triple == 2'd2) begin
          res.valid        = 1'b1;
          res.kind         = KIND_PIXEL;
          res.red          = data_byte;
          res.green        = cur_green;
          res.blue         = cur_blue;
          res.pixel_column = cur_col;
          res.pixel_row    = cur_row;
          res.image_width  = cur_width[15:0];
          res.image_height = cur_height[15:0];
          res.last_pixel   = row_end && image_end;
        end
      end
      default: begin
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      header_index <= '0;
      width_reg    <= '0;
      height_reg   <= '0;
      column_count <= '0;
      row_count    <= '0;
      triple_index <= '0;
      held_blue    <= '0;
      held_green   <= '0;
      padding_left <= '0;
    end else if (step) begin
      phase        <= phase_next;
      header_index <= header_index_next;
      width_reg    <= width_reg_next;
      height_reg   <= height_reg_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
      triple_index <= triple_index_next;
      held_blue    <= held_blue_next;
      held_green   <= held_green_next;
      padding_left <= padding_left_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bmp_rgb24_stream_parser.sv -----
// Throughput one byte per cycle when the output is not stalled; a result passes the
// input register, then the result register, on its way out.
// The single-step parser core sets the rate: each byte updates the file state once.
// A stalled output holds one result and one buffered byte before s_tready drops.
// Synchronous active-high reset empties both registers and returns the parser to
// idle; bytes before the first file start are ignored.
`default_nettype none
`include "bmp_rgb24_stream_parser_macros.svh"

module bmp_rgb24_stream_parser
  import bmp24_pkg::*;
#(
  parameter int unsigned DIM_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] file_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata,   // red, green, blue, pixel_column, pixel_row,
                                      // image_width, image_height
  output logic [1:0]       m_tuser,   // [1:0] kind
  output logic             m_tlast    // last_pixel
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic       out_valid;
  result_t    out_res;
  result_t    core_res;
  logic       advance;

  // Input byte moves into the core when the result register is free or draining
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  bmp24_parse #(
    .DIM_BITS (DIM_BITS)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .data_byte  (in_byte),
    .file_start (in_start),
    .res        (core_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= core_res.valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last_pixel;
  assign m_tdata  = {out_res.image_height, out_res.image_width, out_res.pixel_row,
                     out_res.pixel_column, out_res.blue, out_res.green, out_res.red};

  // Checks
  `BMP_ASSERT(a_last_is_pixel, (m_tvalid && m_tlast) |-> (m_tuser == KIND_PIXEL))
  `BMP_ASSERT(a_full_blocks_input, (in_valid && out_valid && !m_tready) |-> !s_tready)
  `BMP_ASSERT(a_non_pixel_no_colour, (m_tvalid && (m_tuser != KIND_PIXEL)) |-> (m_tdata[55:0] == 56'd0))

endmodule

`default_nettype wire

// ----- tb/bmp_rgb24_stream_parser_test.sv -----
// Self-checking testbench for bmp_rgb24_stream_parser: byte stream in, header and pixel reports out.
// A behavioural parser in the bench predicts every report; needs bmp24_pkg and the parser RTL.
`default_nettype none

module bmp_rgb24_stream_parser_test;
  import bmp24_pkg::*;

  localparam int unsigned DIM_BITS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TOTAL_BYTES = 1850;
  localparam int QUIET_BYTES = 300;
  localparam int HEADER_BYTES = 54;

  // One report as the parser should emit it
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] column;
    logic [15:0] row;
    logic [15:0] width;
    logic [15:0] height;
    logic        last;
  } parse_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tuser = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [87:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  parse_report_t predicted_reports[$];
  int          failures = 0;
  int          cycle_count = 0;
  int          sent_bytes = 0;
  bit          quiet = 1'b0;
  bit          calm_tx = 1'b0;
  bit          calm_rx = 1'b0;
  int          stall_left = 0;

  // Bench copy of the parser state
  phase_t      parse_phase;
  logic [5:0]  hdr_pos;
  logic [31:0] cap_width;
  logic [31:0] cap_height;
  logic [15:0] col_pos;
  logic [15:0] row_pos;
  logic [1:0]  triple_pos;
  logic [7:0]  held_b;
  logic [7:0]  held_g;
  logic [1:0]  pad_left;

  bmp_rgb24_stream_parser #(.DIM_BITS(DIM_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Dimension must fit both the parameter width and the 16-bit counters
  function automatic bit dim_in_range(input logic [31:0] v);
    return (v[31:16] == 16'd0) && ((64'(v) >> DIM_BITS) == 64'd0);
  endfunction

  function automatic void clear_file_state();
    hdr_pos = '0;
    cap_width = '0;
    cap_height = '0;
    col_pos = '0;
    row_pos = '0;
    triple_pos = '0;
    held_b = '0;
    held_g = '0;
    pad_left = '0;
  endfunction

  // Advance the bench parser by one byte; returns 1 when a report is due
  function automatic bit parse_byte(input logic [7:0] b, input bit start,
                                    output parse_report_t rep);
    int k;
    rep = '0;
    if (start) begin
      parse_phase = PH_HEADER;
      clear_file_state();
    end
    case (parse_phase)
      PH_HEADER: begin
        if ((hdr_pos == IDX_MAGIC0 && b != MAGIC_FIRST) ||
            (hdr_pos == IDX_MAGIC1 && b != MAGIC_SECOND)) begin
          parse_phase = PH_DONE;
          rep.kind = KIND_NOT_BMP;
          return 1'b1;
        end
        if (hdr_pos >= WIDTH_OFS && hdr_pos < WIDTH_OFS + 6'd4) begin
          k = int'(hdr_pos) - int'(WIDTH_OFS);
          cap_width |= 32'(b) << (8 * k);
        end else if (hdr_pos >= HEIGHT_OFS && hdr_pos < HEIGHT_OFS + 6'd4) begin
          k = int'(hdr_pos) - int'(HEIGHT_OFS);
          cap_height |= 32'(b) << (8 * k);
        end
        if (hdr_pos >= HEADER_LAST) begin
          rep.width = cap_width[15:0];
          rep.height = cap_height[15:0];
          if (!dim_in_range(cap_width) || !dim_in_range(cap_height)) begin
            parse_phase = PH_DONE;
            rep.kind = KIND_TOO_LARGE;
            return 1'b1;
          end
          rep.kind = KIND_DIMS;
          parse_phase = (cap_width != 0 && cap_height != 0) ? PH_PIXELS : PH_DONE;
          return 1'b1;
        end
        hdr_pos = hdr_pos + 6'd1;
        return 1'b0;
      end
      PH_PIXELS: begin
        if (triple_pos == 2'd0) begin
          held_b = b;
          triple_pos = 2'd1;
          return 1'b0;
        end
        if (triple_pos == 2'd1) begin
          held_g = b;
          triple_pos = 2'd2;
          return 1'b0;
        end
        triple_pos = 2'd0;
        rep.kind = KIND_PIXEL;
        rep.red = b;
        rep.green = held_g;
        rep.blue = held_b;
        rep.column = col_pos;
        rep.row = row_pos;
        rep.width = cap_width[15:0];
        rep.height = cap_height[15:0];
        if (32'(col_pos) + 32'd1 >= cap_width) begin
          if (32'(row_pos) + 32'd1 >= cap_height) begin
            rep.last = 1'b1;
            parse_phase = PH_DONE;
            return 1'b1;
          end
          col_pos = '0;
          row_pos = row_pos + 16'd1;
          pad_left = cap_width[1:0];
          if (pad_left != 2'd0) parse_phase = PH_PADDING;
        end else begin
          col_pos = col_pos + 16'd1;
        end
        return 1'b1;
      end
      PH_PADDING: begin
        if (pad_left > 2'd0) pad_left = pad_left - 2'd1;
        if (pad_left == 2'd0) parse_phase = PH_PIXELS;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Present one byte, wait for the transaction, then record any report it causes
  task automatic send_byte(input logic [7:0] b, input bit start);
    parse_report_t rep;
    @(negedge clk);
    if ($urandom_range(0, 199) == 0) calm_tx = !calm_tx;
    if (!quiet && !calm_tx && $urandom_range(0, 4) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    s_tuser = start;
    do @(posedge clk); while (!s_tready);
    sent_bytes++;
    if (parse_byte(b, start, rep)) predicted_reports = {predicted_reports, rep};
  endtask

  // Hold the input quiet until every predicted report has been seen
  task automatic wait_for_reports();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk);
  endtask

  // Build a whole file (header, pixel rows with padding, trailing junk) and stream it.
  // cut < 0 keeps the whole file; fill < 0 gives random pixel bytes.
  task automatic send_file(input logic [31:0] w, input logic [31:0] h,
                           input int trailing, input int cut, input int fill);
    logic [7:0] file_bytes[$];
    logic [7:0] v;
    int n;
    n = 0;
    for (int k = 0; k < HEADER_BYTES; k++) begin
      if (k == int'(IDX_MAGIC0)) v = MAGIC_FIRST;
      else if (k == int'(IDX_MAGIC1)) v = MAGIC_SECOND;
      else if (k >= int'(WIDTH_OFS) && k < int'(WIDTH_OFS) + 4)
        v = w[8 * (k - int'(WIDTH_OFS)) +: 8];
      else if (k >= int'(HEIGHT_OFS) && k < int'(HEIGHT_OFS) + 4)
        v = h[8 * (k - int'(HEIGHT_OFS)) +: 8];
      else v = 8'($urandom);
      file_bytes = {file_bytes, v};
    end
    if (dim_in_range(w) && dim_in_range(h) && w != 0 && h != 0) begin
      for (int r = 0; r < int'(h); r++) begin
        for (int c = 0; c < 3 * int'(w); c++) begin
          if (fill < 0) v = 8'($urandom);
          else v = (n % 2 == 1) ? ~8'(fill) : 8'(fill);
          n++;
          file_bytes = {file_bytes, v};
        end
        for (int p = 0; p < int'(w[1:0]); p++) file_bytes = {file_bytes, 8'($urandom)};
      end
    end
    for (int t = 0; t < trailing; t++) file_bytes = {file_bytes, 8'($urandom)};
    if (cut >= 1)
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0);
  endtask

  // File whose magic goes wrong on the first or the second byte
  task automatic send_bad_magic(input bit on_second);
    logic [7:0] v;
    if (on_second) begin
      send_byte(MAGIC_FIRST, 1'b1);
      v = 8'($urandom);
      if (v == MAGIC_SECOND) v = ~v;
      send_byte(v, 1'b0);
    end else begin
      v = 8'($urandom);
      if (v == MAGIC_FIRST) v = ~v;
      send_byte(v, 1'b1);
    end
    repeat ($urandom_range(0, 6)) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic test_idle_bytes();
    send_byte(MAGIC_FIRST, 1'b0);
    send_byte(MAGIC_SECOND, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_bad_magic();
    send_byte(MAGIC_SECOND, 1'b1);
    send_byte(MAGIC_FIRST, 1'b0);
    send_byte(MAGIC_SECOND, 1'b0);
    send_bad_magic(1'b0);
    send_bad_magic(1'b1);
  endtask

  // Zero and extreme dimensions, oversized and top-down headers, truncated files
  task automatic test_header_cases();
    send_file(32'd0, 32'd5, 3, -1, -1);
    send_file(32'd7, 32'd0, 0, -1, -1);
    send_file(32'h0000_FFFF, 32'd0, 2, -1, -1);
    send_file(32'd0, 32'h0000_FFFF, 0, -1, -1);
    send_file(32'h0001_0000, 32'd1, 4, -1, -1);
    send_file(32'd1, 32'h0001_0000, 0, -1, -1);
    send_file(32'd2, 32'h8000_0002, 3, -1, -1);
    send_file(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, -1, -1);
    send_file(32'd3, 32'd3, 0, 20, -1);
    send_file(32'd3, 32'd3, 0, 60, -1);
  endtask

  // Every padding length and both pixel byte extremes
  task automatic test_small_images();
    send_file(32'd1, 32'd1, 3, -1, 8'h00);
    send_file(32'd2, 32'd2, 2, -1, 8'hFF);
    send_file(32'd3, 32'd2, 1, -1, -1);
    send_file(32'd4, 32'd2, 0, -1, -1);
    send_file(32'd5, 32'd2, 5, -1, -1);
  endtask

  // Sender holds off until the output side has caught up, then resumes
  task automatic test_drain_pause();
    send_file(32'd6, 32'd3, 2, -1, -1);
    wait_for_reports();
    send_file(32'd3, 32'd1, 0, -1, -1);
    wait_for_reports();
  endtask

  // Mostly well-formed small images, the rest broken or noise
  task automatic random_file();
    int pick;
    int w;
    int h;
    int cut;
    logic [31:0] bw;
    logic [31:0] bh;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      w = $urandom_range(1, 9);
      if ($urandom_range(0, 9) == 0) w = $urandom_range(10, 24);
      h = $urandom_range(1, 4);
      cut = -1;
      if (pick >= 64) cut = $urandom_range(1, HEADER_BYTES + (3 * w + w % 4) * h);
      send_file(w, h, $urandom_range(0, 4), cut, -1);
    end else if (pick < 80) begin
      send_bad_magic($urandom_range(0, 1));
    end else if (pick < 87) begin
      bw = $urandom_range(1, 8);
      bh = $urandom_range(1, 8);
      case ($urandom_range(0, 2))
        0: bw = $urandom | (32'h1 << $urandom_range(16, 31));
        1: bh = $urandom | 32'h8000_0000;
        default: begin
          bw = $urandom;
          bh = $urandom | 32'h0001_0000;
        end
      endcase
      send_file(bw, bh, $urandom_range(0, 3), -1, -1);
    end else if (pick < 93) begin
      bw = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(0, 65535));
      bh = (bw == 0) ? 32'($urandom_range(0, 65535)) : 32'd0;
      send_file(bw, bh, $urandom_range(0, 3), -1, -1);
    end else begin
      repeat ($urandom_range(1, 6))
        send_byte(8'($urandom), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_random_files();
    while (sent_bytes < TOTAL_BYTES - QUIET_BYTES) random_file();
  endtask

  // Closing stretch with both sides running flat out
  task automatic test_back_to_back();
    quiet = 1'b1;
    while (sent_bytes < TOTAL_BYTES) random_file();
  endtask

  // Output side: random stall bursts, with calm stretches
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) calm_rx = !calm_rx;
      if (quiet || calm_rx) begin
        m_tready = 1'b1;
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        m_tready = 1'b0;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Compare each report transaction with the oldest prediction
  always @(posedge clk) begin : check_reports
    parse_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_reports.size() == 0) begin
        $error("report with none predicted: kind %0d", m_tuser);
        failures++;
      end else begin
        want = predicted_reports.pop_front();
        check_field("kind", 16'(want.kind), 16'(m_tuser));
        check_field("red", 16'(want.red), 16'(m_tdata[7:0]));
        check_field("green", 16'(want.green), 16'(m_tdata[15:8]));
        check_field("blue", 16'(want.blue), 16'(m_tdata[23:16]));
        check_field("pixel_column", want.column, m_tdata[39:24]);
        check_field("pixel_row", want.row, m_tdata[55:40]);
        check_field("image_width", want.width, m_tdata[71:56]);
        check_field("image_height", want.height, m_tdata[87:72]);
        check_field("last_pixel", 16'(want.last), 16'(m_tlast));
      end
    end
  end

  initial begin
    parse_phase = PH_IDLE;
    clear_file_state();
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_idle_bytes();
    test_bad_magic();
    test_header_cases();
    test_small_images();
    test_drain_pause();
    test_random_files();
    test_back_to_back();

    // Let the last reports through, then a short settling window
    wait_for_reports();
    repeat (16) @(posedge clk);
    if (failures == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
